// ===== sv/rcsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_pkg: shared types and constants of the seconds calendar clock
// Controller states, datapath commands, status, and calendar helpers.
// ----------------------------------------------------------------------------
package rcsd_pkg;

    localparam int EPOCH_YEAR  = 2000;
    localparam int COUNT_WIDTH = 32;

    // Position of the epoch year in the leap cycles
    localparam int EPOCH_Y4   = EPOCH_YEAR % 4;
    localparam int EPOCH_Y100 = EPOCH_YEAR % 100;
    localparam int EPOCH_Y400 = EPOCH_YEAR % 400;

    // Weekday of January 1 of the epoch year, 0 is Sunday
    localparam int EPOCH_WDAY = (1 + 5 * ((EPOCH_YEAR - 1) % 4)
                                 + 4 * ((EPOCH_YEAR - 1) % 100)
                                 + 6 * ((EPOCH_YEAR - 1) % 400)) % 7;

    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN  = 17'd60;
    localparam logic [16:0] HOUR_PER_DAY = 17'd24;
    localparam logic [16:0] DAY_PER_WEEK = 17'd7;

    // Reciprocals floor(2^32 / d); the estimate they give is low by at most one
    localparam logic [31:0] RCP_DAY  = 32'(64'h1_0000_0000 / 64'd86400);
    localparam logic [31:0] RCP_HOUR = 32'(64'h1_0000_0000 / 64'd3600);
    localparam logic [31:0] RCP_MIN  = 32'(64'h1_0000_0000 / 64'd60);
    localparam logic [31:0] RCP_HPD  = 32'(64'h1_0000_0000 / 64'd24);
    localparam logic [31:0] RCP_WEEK = 32'(64'h1_0000_0000 / 64'd7);

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_SET  = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_TICK, S_HS_START, S_HS_WAIT, S_DH_WAIT,
        S_SET_INIT, S_SET_YEAR, S_SET_MON, S_SET_FIN, S_DEC_START,
        S_DAY_WAIT, S_WD_WAIT, S_YEAR, S_MON, S_HR_WAIT, S_MIN_WAIT, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_TICK, OP_HS_START, OP_HS_SAVE, OP_DH_SAVE,
        OP_CLEAR, OP_SET_INIT, OP_SET_YSTEP, OP_SET_MSTEP, OP_SET_MUL,
        OP_SET_FIN, OP_DEC_START, OP_DEC_DAYS, OP_DEC_WD, OP_YSTEP,
        OP_MSTEP, OP_HOUR, OP_MIN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       apply;
        logic       clr;
        logic       div_busy;
        logic       set_ymore;
        logic       set_mmore;
        logic       ymore;
        logic       mmore;
    } t_sts;

    // Days in month m (0 is January)
    function automatic logic [4:0] dim(input logic leap, input logic [3:0] m);
        logic [3:0] mm;
        mm = (m > 4'd6) ? m - 4'd1 : m;
        if (m == 4'd1) begin
            dim = 5'd28 + {4'd0, leap};
        end else begin
            dim = mm[0] ? 5'd30 : 5'd31;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/rcsd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_div: divider by a constant through reciprocal multiplication
// Estimates the quotient, forms the remainder and corrects once.
// ----------------------------------------------------------------------------
module rcsd_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [16:0] i_divisor,
    input  wire logic [31:0] i_recip,
    output logic             o_busy,
    output logic [31:0]      o_quo,
    output logic [16:0]      o_rem
);
    logic [31:0] r_dvd;
    logic [16:0] r_dsr;
    logic [31:0] r_rcp;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [1:0]  r_phase;
    logic        r_busy;
    logic [63:0] w_prod;

    assign w_prod = {32'd0, r_dvd} * {32'd0, r_rcp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_phase <= '0;
            r_dvd   <= i_dividend;
            r_dsr   <= i_divisor;
            r_rcp   <= i_recip;
        end else if (r_busy) begin
            r_phase <= r_phase + 2'd1;
            case (r_phase)
                2'd0: begin
                    // quotient estimate, low by at most one
                    r_quo <= w_prod[63:32];
                end
                2'd1: begin
                    r_rem <= r_dvd - r_quo * {15'd0, r_dsr};
                end
                default: begin
                    // fold the estimate error back in
                    if (r_rem >= {15'd0, r_dsr}) begin
                        r_quo <= r_quo + 32'd1;
                        r_rem <= r_rem - {15'd0, r_dsr};
                    end
                    r_busy <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[16:0];
endmodule
`default_nettype wire

// ===== sv/rcsd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_dp: calendar clock datapath
// Counters, date walk registers, set accumulator and the shared divider.
// ----------------------------------------------------------------------------
module rcsd_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rcsd_pkg::t_cmd i_cmd,
    output rcsd_pkg::t_sts     o_sts,
    input  wire logic [1:0]    i_kind,
    input  wire logic          i_apply,
    input  wire logic [7:0]    i_set_year,
    input  wire logic [3:0]    i_set_month,
    input  wire logic [4:0]    i_set_day,
    input  wire logic [4:0]    i_set_hour,
    input  wire logic [5:0]    i_set_minute,
    input  wire logic [5:0]    i_set_second,
    output logic [11:0]        o_year,
    output logic [3:0]         o_month,
    output logic [4:0]         o_day,
    output logic [4:0]         o_hour,
    output logic [5:0]         o_minute,
    output logic [5:0]         o_second,
    output logic [2:0]         o_weekday,
    output logic               o_valid_res,
    output logic [31:0]        o_seconds_count,
    output logic [31:0]        o_uptime_seconds,
    output logic [11:0]        o_sec_of_hour,
    output logic [4:0]         o_hour_of_day
);
    localparam int CW = rcsd_pkg::COUNT_WIDTH;

    logic [1:0]    r_kind;
    logic          r_apply;
    logic          r_clr;
    logic [7:0]    r_syrs;
    logic [3:0]    r_smon;
    logic [4:0]    r_sday;
    logic [16:0]   r_tset;
    logic [CW-1:0] r_epoch;
    logic [CW-1:0] r_uptime;
    logic [11:0]   r_hsec;
    logic [4:0]    r_dhour;
    logic [31:0]   r_acc;
    logic [31:0]   r_prod;
    logic [7:0]    r_yi;
    logic [3:0]    r_mon;
    logic [11:0]   r_year;
    logic [1:0]    r_y4;
    logic [6:0]    r_y100;
    logic [8:0]    r_y400;
    logic [15:0]   r_days;
    logic [16:0]   r_tod;
    logic [2:0]    r_wd;
    logic [4:0]    r_hour;
    logic [5:0]    r_min;
    logic [5:0]    r_sec;

    logic          w_leap;
    logic [8:0]    w_diy;
    logic [4:0]    w_dim;
    logic [3:0]    w_wsum;
    logic          w_dstart;
    logic [31:0]   w_dvd;
    logic [16:0]   w_dsr;
    logic [31:0]   w_rcp;
    logic          w_busy;
    logic [31:0]   w_quo;
    logic [16:0]   w_rem;

    assign w_leap = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
    assign w_diy  = 9'd365 + {8'd0, w_leap};
    assign w_dim  = rcsd_pkg::dim(w_leap, r_mon);
    assign w_wsum = {1'b0, w_rem[2:0]} + 4'(rcsd_pkg::EPOCH_WDAY);

    always_comb begin
        w_dstart = 1'b0;
        w_dvd    = r_epoch;
        w_dsr    = rcsd_pkg::SEC_PER_DAY;
        w_rcp    = rcsd_pkg::RCP_DAY;
        case (i_cmd.op)
            rcsd_pkg::OP_HS_START: begin
                w_dstart = 1'b1;
                w_dsr    = rcsd_pkg::SEC_PER_HOUR;
                w_rcp    = rcsd_pkg::RCP_HOUR;
            end
            rcsd_pkg::OP_HS_SAVE: begin
                w_dstart = 1'b1;
                w_dvd    = w_quo;
                w_dsr    = rcsd_pkg::HOUR_PER_DAY;
                w_rcp    = rcsd_pkg::RCP_HPD;
            end
            rcsd_pkg::OP_DEC_START: begin
                w_dstart = 1'b1;
            end
            rcsd_pkg::OP_DEC_DAYS: begin
                w_dstart = 1'b1;
                w_dvd    = w_quo;
                w_dsr    = rcsd_pkg::DAY_PER_WEEK;
                w_rcp    = rcsd_pkg::RCP_WEEK;
            end
            rcsd_pkg::OP_DEC_WD: begin
                w_dstart = 1'b1;
                w_dvd    = {15'd0, r_tod};
                w_dsr    = rcsd_pkg::SEC_PER_HOUR;
                w_rcp    = rcsd_pkg::RCP_HOUR;
            end
            rcsd_pkg::OP_HOUR: begin
                w_dstart = 1'b1;
                w_dvd    = {15'd0, w_rem};
                w_dsr    = rcsd_pkg::SEC_PER_MIN;
                w_rcp    = rcsd_pkg::RCP_MIN;
            end
            default: begin
                w_dstart = 1'b0;
            end
        endcase
    end

    rcsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_dvd),
        .i_divisor  (w_dsr),
        .i_recip    (w_rcp),
        .o_busy     (w_busy),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch  <= '0;
            r_uptime <= '0;
            r_hsec   <= '0;
            r_dhour  <= '0;
        end else begin
            case (i_cmd.op)
                rcsd_pkg::OP_LOAD: begin
                    r_kind  <= i_kind;
                    r_apply <= i_apply;
                    r_clr   <= (i_set_year == 8'd0) && (i_set_month == 4'd0)
                            && (i_set_day == 5'd0) && (i_set_hour == 5'd0)
                            && (i_set_minute == 6'd0) && (i_set_second == 6'd0);
                    r_syrs  <= i_set_year;
                    // clamp the month into 1 to 12
                    r_smon  <= (i_set_month == 4'd0) ? 4'd1 :
                               (i_set_month > 4'd12) ? 4'd12 : i_set_month;
                    r_sday  <= i_set_day;
                    r_tset  <= 17'(i_set_second) + 17'(i_set_minute) * 17'd60
                             + 17'(i_set_hour) * 17'd3600;
                end
                rcsd_pkg::OP_TICK: begin
                    r_epoch  <= r_epoch + CW'(1);
                    r_uptime <= r_uptime + CW'(1);
                end
                rcsd_pkg::OP_HS_SAVE: begin
                    r_hsec <= w_rem[11:0];
                end
                rcsd_pkg::OP_DH_SAVE: begin
                    r_dhour <= w_rem[4:0];
                end
                rcsd_pkg::OP_CLEAR: begin
                    r_epoch <= '0;
                end
                rcsd_pkg::OP_SET_INIT: begin
                    // day zero wraps to minus one day
                    r_acc  <= {27'd0, r_sday} - 32'd1;
                    r_yi   <= '0;
                    r_mon  <= '0;
                    r_year <= 12'(rcsd_pkg::EPOCH_YEAR);
                    r_y4   <= 2'(rcsd_pkg::EPOCH_Y4);
                    r_y100 <= 7'(rcsd_pkg::EPOCH_Y100);
                    r_y400 <= 9'(rcsd_pkg::EPOCH_Y400);
                end
                rcsd_pkg::OP_SET_YSTEP, rcsd_pkg::OP_YSTEP: begin
                    if (i_cmd.op == rcsd_pkg::OP_SET_YSTEP) begin
                        r_acc <= r_acc + {23'd0, w_diy};
                        r_yi  <= r_yi + 8'd1;
                    end else begin
                        r_days <= r_days - {7'd0, w_diy};
                    end
                    r_year <= r_year + 12'd1;
                    r_y4   <= r_y4 + 2'd1;
                    r_y100 <= (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                    r_y400 <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end
                rcsd_pkg::OP_SET_MSTEP: begin
                    r_acc <= r_acc + {27'd0, w_dim};
                    r_mon <= r_mon + 4'd1;
                end
                rcsd_pkg::OP_SET_MUL: begin
                    r_prod <= r_acc * {15'd0, rcsd_pkg::SEC_PER_DAY};
                end
                rcsd_pkg::OP_SET_FIN: begin
                    r_epoch <= r_prod + {15'd0, r_tset};
                end
                rcsd_pkg::OP_DEC_DAYS: begin
                    r_days <= w_quo[15:0];
                    r_tod  <= w_rem;
                end
                rcsd_pkg::OP_DEC_WD: begin
                    r_wd   <= (w_wsum >= 4'd7) ? 3'(w_wsum - 4'd7) : w_wsum[2:0];
                    r_mon  <= '0;
                    r_year <= 12'(rcsd_pkg::EPOCH_YEAR);
                    r_y4   <= 2'(rcsd_pkg::EPOCH_Y4);
                    r_y100 <= 7'(rcsd_pkg::EPOCH_Y100);
                    r_y400 <= 9'(rcsd_pkg::EPOCH_Y400);
                end
                rcsd_pkg::OP_MSTEP: begin
                    r_days <= r_days - {11'd0, w_dim};
                    r_mon  <= r_mon + 4'd1;
                end
                rcsd_pkg::OP_HOUR: begin
                    r_hour <= w_quo[4:0];
                end
                rcsd_pkg::OP_MIN: begin
                    r_min <= w_quo[5:0];
                    r_sec <= w_rem[5:0];
                end
                default: begin
                    r_epoch <= r_epoch;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.apply     = r_apply;
        o_sts.clr       = r_clr;
        o_sts.div_busy  = w_busy;
        o_sts.set_ymore = r_yi != r_syrs;
        o_sts.set_mmore = ({1'b0, r_mon} + 5'd1) < {1'b0, r_smon};
        o_sts.ymore     = r_days >= {7'd0, w_diy};
        o_sts.mmore     = (r_mon < 4'd11) && (r_days >= {11'd0, w_dim});
    end

    assign o_year           = r_year;
    assign o_month          = r_mon + 4'd1;
    assign o_day            = r_days[4:0] + 5'd1;
    assign o_hour           = r_hour;
    assign o_minute         = r_min;
    assign o_second         = r_sec;
    assign o_weekday        = r_wd;
    assign o_valid_res      = r_year != 12'(rcsd_pkg::EPOCH_YEAR);
    assign o_seconds_count  = r_epoch;
    assign o_uptime_seconds = r_uptime;
    assign o_sec_of_hour    = r_hsec;
    assign o_hour_of_day    = r_dhour;
endmodule
`default_nettype wire

// ===== sv/rcsd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_ctrl: calendar clock sequencer
// Steps the datapath through tick, set and decode for one item at a time.
// ----------------------------------------------------------------------------
module rcsd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  wire logic           i_stall,
    input  wire rcsd_pkg::t_sts i_sts,
    output rcsd_pkg::t_cmd      o_cmd
);
    rcsd_pkg::t_state r_state;
    rcsd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcsd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = rcsd_pkg::OP_NONE;
        o_stall   = 1'b1;
        o_valid   = 1'b0;
        case (r_state)
            rcsd_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = rcsd_pkg::OP_LOAD;
                    n_state  = rcsd_pkg::S_DISPATCH;
                end
            end
            rcsd_pkg::S_DISPATCH: begin
                if (i_sts.kind == rcsd_pkg::KIND_TICK) begin
                    n_state = rcsd_pkg::S_TICK;
                end else if (i_sts.kind == rcsd_pkg::KIND_SET && i_sts.apply) begin
                    n_state = rcsd_pkg::S_SET_INIT;
                end else begin
                    n_state = rcsd_pkg::S_DEC_START;
                end
            end
            rcsd_pkg::S_TICK: begin
                o_cmd.op = rcsd_pkg::OP_TICK;
                n_state  = rcsd_pkg::S_HS_START;
            end
            rcsd_pkg::S_HS_START: begin
                o_cmd.op = rcsd_pkg::OP_HS_START;
                n_state  = rcsd_pkg::S_HS_WAIT;
            end
            rcsd_pkg::S_HS_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = rcsd_pkg::OP_HS_SAVE;
                    n_state  = rcsd_pkg::S_DH_WAIT;
                end
            end
            rcsd_pkg::S_DH_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = rcsd_pkg::OP_DH_SAVE;
                    n_state  = rcsd_pkg::S_DEC_START;
                end
            end
            rcsd_pkg::S_SET_INIT: begin
                if (i_sts.clr) begin
                    o_cmd.op = rcsd_pkg::OP_CLEAR;
                    n_state  = rcsd_pkg::S_DEC_START;
                end else begin
                    o_cmd.op = rcsd_pkg::OP_SET_INIT;
                    n_state  = rcsd_pkg::S_SET_YEAR;
                end
            end
            rcsd_pkg::S_SET_YEAR: begin
                if (i_sts.set_ymore) begin
                    o_cmd.op = rcsd_pkg::OP_SET_YSTEP;
                end else begin
                    n_state = rcsd_pkg::S_SET_MON;
                end
            end
            rcsd_pkg::S_SET_MON: begin
                if (i_sts.set_mmore) begin
                    o_cmd.op = rcsd_pkg::OP_SET_MSTEP;
                end else begin
                    o_cmd.op = rcsd_pkg::OP_SET_MUL;
                    n_state  = rcsd_pkg::S_SET_FIN;
                end
            end
            rcsd_pkg::S_SET_FIN: begin
                o_cmd.op = rcsd_pkg::OP_SET_FIN;
                n_state  = rcsd_pkg::S_DEC_START;
            end
            rcsd_pkg::S_DEC_START: begin
                o_cmd.op = rcsd_pkg::OP_DEC_START;
                n_state  = rcsd_pkg::S_DAY_WAIT;
            end
            rcsd_pkg::S_DAY_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = rcsd_pkg::OP_DEC_DAYS;
                    n_state  = rcsd_pkg::S_WD_WAIT;
                end
            end
            rcsd_pkg::S_WD_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = rcsd_pkg::OP_DEC_WD;
                    n_state  = rcsd_pkg::S_YEAR;
                end
            end
            rcsd_pkg::S_YEAR: begin
                if (i_sts.ymore) begin
                    o_cmd.op = rcsd_pkg::OP_YSTEP;
                end else begin
                    n_state = rcsd_pkg::S_MON;
                end
            end
            rcsd_pkg::S_MON: begin
                if (i_sts.mmore) begin
                    o_cmd.op = rcsd_pkg::OP_MSTEP;
                end else begin
                    n_state = rcsd_pkg::S_HR_WAIT;
                end
            end
            rcsd_pkg::S_HR_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = rcsd_pkg::OP_HOUR;
                    n_state  = rcsd_pkg::S_MIN_WAIT;
                end
            end
            rcsd_pkg::S_MIN_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = rcsd_pkg::OP_MIN;
                    n_state  = rcsd_pkg::S_OUT;
                end
            end
            rcsd_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = rcsd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcsd_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/rtc_calendar_seconds_date.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_calendar_seconds_date: seconds-based calendar clock
// Counts epoch seconds, loads them from a date and decodes them per item.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  input    i_valid / o_stall  i_kind, i_apply, i_set_* (one item)
//  output   o_valid / i_stall  o_year .. o_hour_of_day (one result per item)
//
//  One item at a time. A read makes four passes of the shared constant
//  divider (the time-of-day pass overlapped with the walks) plus the year
//  walk (one step per year since the epoch, up to 136) and the month walk
//  (up to 11 steps). A tick adds an increment and two divider passes; a set
//  adds one step per set year (up to 255), up to 11 month steps, an init, a
//  multiply and a final add; a clear adds a single clear step.
//  Reset clears the counters and returns the sequencer to idle.
//  o_stall stays high from acceptance until the result is taken; a stalled
//  result holds its value.
// ----------------------------------------------------------------------------
module rtc_calendar_seconds_date (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic        i_apply,
    input  wire logic [7:0]  i_set_year,
    input  wire logic [3:0]  i_set_month,
    input  wire logic [4:0]  i_set_day,
    input  wire logic [4:0]  i_set_hour,
    input  wire logic [5:0]  i_set_minute,
    input  wire logic [5:0]  i_set_second,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [11:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second,
    output logic [2:0]       o_weekday,
    output logic             o_valid_res,
    output logic [31:0]      o_seconds_count,
    output logic [31:0]      o_uptime_seconds,
    output logic [11:0]      o_sec_of_hour,
    output logic [4:0]       o_hour_of_day
);
    // command from the sequencer, status back from the datapath
    rcsd_pkg::t_cmd w_cmd;
    rcsd_pkg::t_sts w_sts;

    rcsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath holds the counters; result fields come straight from its
    // registers, so they stay put while the output is stalled
    rcsd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_kind           (i_kind),
        .i_apply          (i_apply),
        .i_set_year       (i_set_year),
        .i_set_month      (i_set_month),
        .i_set_day        (i_set_day),
        .i_set_hour       (i_set_hour),
        .i_set_minute     (i_set_minute),
        .i_set_second     (i_set_second),
        .o_year           (o_year),
        .o_month          (o_month),
        .o_day            (o_day),
        .o_hour           (o_hour),
        .o_minute         (o_minute),
        .o_second         (o_second),
        .o_weekday        (o_weekday),
        .o_valid_res      (o_valid_res),
        .o_seconds_count  (o_seconds_count),
        .o_uptime_seconds (o_uptime_seconds),
        .o_sec_of_hour    (o_sec_of_hour),
        .o_hour_of_day    (o_hour_of_day)
    );
endmodule
`default_nettype wire

// ===== sv/rcsd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_checker: port-level checks of the calendar clock
// Watches the handshakes and result fields over time.
// ----------------------------------------------------------------------------
module rcsd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [11:0] o_year,
    input wire logic [3:0]  o_month,
    input wire logic        o_valid_res,
    input wire logic [31:0] o_seconds_count
);
    // no new item is taken while a result waits
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("item accepted while result pending");

    // one result per item
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("result repeated");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_seconds_count)))
        else $error("stalled result changed");

    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_valid_res == (o_year != 12'(rcsd_pkg::EPOCH_YEAR))))
        else $error("valid flag disagrees with year");

    a_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1 && o_month <= 4'd12))
        else $error("month out of range");
endmodule

bind rtc_calendar_seconds_date rcsd_checker u_rcsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_year          (o_year),
    .o_month         (o_month),
    .o_valid_res     (o_valid_res),
    .o_seconds_count (o_seconds_count)
);
`default_nettype wire
